@@ rtl/tcprto_pkg.sv @@
// Package for the TCP timeout and congestion window controller.
// Holds the word types, field widths, fixed-point constants and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcprto_pkg;

    // Field and datapath widths
    localparam int TIME_W    = 20;               // times in 1/8 ms units
    localparam int FRAC_BITS = 16;               // window fraction bits
    localparam int THR_W     = 11;               // threshold / window whole part
    localparam int WIN_W     = THR_W + FRAC_BITS; // 11.16 window
    localparam int ALU_W     = 28;               // shared adder width
    localparam int QUOT_W    = FRAC_BITS + 1;    // reciprocal step width
    localparam int CNT_W     = 5;                // division step counter
    localparam int CFG_W     = 20;               // config data width
    localparam int CFG_IDX_W = 2;

    // Constants
    localparam logic [TIME_W-1:0] TIME_MAX      = '1;
    localparam logic [TIME_W-1:0] RTT_RESET     = TIME_W'(960);
    localparam logic [WIN_W-1:0]  ONE_SEG       = WIN_W'(1) << FRAC_BITS;
    localparam logic [WIN_W-1:0]  THREE_SEG     = WIN_W'(3) << FRAC_BITS;
    localparam logic [WIN_W-1:0]  WIN_LIMIT     = WIN_W'(1024) << FRAC_BITS;
    localparam logic [THR_W-1:0]  SSTH_RESET    = THR_W'(64);
    localparam logic [TIME_W-1:0] MIN_RTO_RESET = TIME_W'(8);
    localparam logic [THR_W-1:0]  FLOOR_RESET   = THR_W'(2);
    localparam logic [CNT_W-1:0]  DIV_TOP       = CNT_W'(FRAC_BITS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SSTH_FLOOR = 2'd1;

    // Input item mode codes
    localparam logic MODE_ACK     = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    typedef struct packed {
        logic              mode;
        logic              sample_valid;
        logic [TIME_W-1:0] rtt_meas;
    } in_word_t;

    typedef struct packed {
        logic [TIME_W-1:0] rto_out;
        logic [THR_W-1:0]  window_whole;
        logic [THR_W-1:0]  ssthresh_out;
        logic              slow_start;
    } out_word_t;

endpackage

`default_nettype wire

@@ rtl/tcp_rto_and_cwnd_control.sv @@
// Top level: TCP retransmission timeout estimator and congestion window control.
// Depends on tcprto_pkg. One shared add/subtract unit driven by a small sequencer.
//
//   channel   direction  handshake              word
//   in        input      in_valid / in_ready    in_word_t  (mode, sample_valid, rtt_meas)
//   out       output     out_valid / out_ready  out_word_t (rto, window, ssthresh, flag)
//   cfg       input      cfg_we                 cfg_index, cfg_data
//
// Per word: a timeout compares the window and sets the flag; an ack with no sample runs the
// window steps; an ack with a sample first updates deviation, smoothed RTT and timeout, with
// an extra step when the sample is below the smoothed RTT. Outside slow start the 17-step
// restoring division of 2^16 by the whole window is added. Every arithmetic step is one pass through the shared adder.
// in_ready is high only in the idle state.
// The finished word sits in an output register; the block takes the next word while it waits.
// Reset (rst_n, asynchronous, active low) restores the estimator state and config registers.
`timescale 1ns / 1ps
`default_nettype none

module tcp_rto_and_cwnd_control (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire tcprto_pkg::in_word_t        in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output tcprto_pkg::out_word_t            out_data,
    input  wire logic                        cfg_we,
    input  wire logic [tcprto_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcprto_pkg::CFG_W-1:0]     cfg_data
);
    import tcprto_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_DIFF_NEG,
        S_DEV3,
        S_DEV,
        S_RTT7,
        S_RTT,
        S_RTO,
        S_RTO_MIN,
        S_WIN_CMP,
        S_DIV,
        S_WIN_ADD,
        S_WIN_SAT,
        S_TO_CMP,
        S_FLAG
    } state_t;

    state_t state_reg, state_next;

    // Estimator state and config
    logic [TIME_W-1:0] rtt_reg, rtt_next;
    logic [TIME_W-1:0] dev_reg, dev_next;
    logic [TIME_W-1:0] rto_reg, rto_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [THR_W-1:0]  ssth_reg, ssth_next;
    logic [TIME_W-1:0] min_rto_reg, min_rto_next;
    logic [THR_W-1:0]  floor_reg, floor_next;

    // Working registers
    logic [TIME_W-1:0] sample_reg, sample_next;
    logic [TIME_W-1:0] diff_reg, diff_next;
    logic [ALU_W-1:0]  acc_reg, acc_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [THR_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_data_reg, out_data_next;

    // Shared adder
    logic [ALU_W-1:0]  op_a, op_b;
    logic              op_sub;
    logic [ALU_W:0]    alu_full;
    logic [ALU_W-1:0]  alu_res;
    logic              alu_borrow;

    logic [THR_W-1:0]  whole;
    logic [THR_W-1:0]  divisor;
    logic              div_bit;
    logic              out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign whole   = win_reg[WIN_W-1:FRAC_BITS];
    assign divisor = (whole == '0) ? THR_W'(1) : whole;
    assign div_bit = (cnt_reg == DIV_TOP);

    // Operand selection per step
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
        unique case (state_reg)
            S_DIFF:
            begin
                op_a   = ALU_W'(sample_reg);
                op_b   = ALU_W'(rtt_reg);
                op_sub = 1'b1;
            end
            S_DIFF_NEG:
            begin
                op_a   = ALU_W'(rtt_reg);
                op_b   = ALU_W'(sample_reg);
                op_sub = 1'b1;
            end
            S_DEV3:
            begin
                op_a = ALU_W'({dev_reg, 1'b0});
                op_b = ALU_W'(dev_reg);
            end
            S_DEV:
            begin
                op_a = acc_reg;
                op_b = ALU_W'(diff_reg);
            end
            S_RTT7:
            begin
                op_a   = ALU_W'({rtt_reg, 3'b000});
                op_b   = ALU_W'(rtt_reg);
                op_sub = 1'b1;
            end
            S_RTT:
            begin
                op_a = acc_reg;
                op_b = ALU_W'(sample_reg);
            end
            S_RTO:
            begin
                op_a = ALU_W'(rtt_reg);
                op_b = ALU_W'({dev_reg, 2'b00});
            end
            S_RTO_MIN:
            begin
                op_a   = acc_reg;
                op_b   = ALU_W'(min_rto_reg);
                op_sub = 1'b1;
            end
            S_WIN_CMP, S_FLAG:
            begin
                op_a   = ALU_W'(win_reg);
                op_b   = ALU_W'({ssth_reg, FRAC_BITS'(0)});
                op_sub = 1'b1;
            end
            S_DIV:
            begin
                op_a   = ALU_W'({rem_reg, div_bit});
                op_b   = ALU_W'(divisor);
                op_sub = 1'b1;
            end
            S_WIN_ADD:
            begin
                op_a = ALU_W'(win_reg);
                op_b = ALU_W'(quot_reg);
            end
            S_WIN_SAT:
            begin
                op_a   = acc_reg;
                op_b   = ALU_W'(WIN_LIMIT);
                op_sub = 1'b1;
            end
            S_TO_CMP:
            begin
                op_a   = ALU_W'(THREE_SEG);
                op_b   = ALU_W'(win_reg);
                op_sub = 1'b1;
            end
            default:
            begin
                op_a   = '0;
                op_b   = '0;
                op_sub = 1'b0;
            end
        endcase
    end

    assign alu_full   = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (ALU_W+1)'(op_sub);
    assign alu_res    = alu_full[ALU_W-1:0];
    assign alu_borrow = op_sub && !alu_full[ALU_W];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rtt_next       = rtt_reg;
        dev_next       = dev_reg;
        rto_next       = rto_reg;
        win_next       = win_reg;
        ssth_next      = ssth_reg;
        min_rto_next   = min_rto_reg;
        floor_next     = floor_reg;
        sample_next    = sample_reg;
        diff_next      = diff_reg;
        acc_next       = acc_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // result taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // config writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_RTO:    min_rto_next = cfg_data[TIME_W-1:0];
                CFG_SSTH_FLOOR: floor_next   = cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = in_data.rtt_meas;
                    if (in_data.mode == MODE_TIMEOUT)
                        state_next = S_TO_CMP;
                    else if (in_data.sample_valid)
                        state_next = S_DIFF;
                    else
                        state_next = S_WIN_CMP;
                end
            end
            // |sample - rtt|
            S_DIFF:
            begin
                diff_next  = alu_res[TIME_W-1:0];
                state_next = alu_borrow ? S_DIFF_NEG : S_DEV3;
            end
            S_DIFF_NEG:
            begin
                diff_next  = alu_res[TIME_W-1:0];
                state_next = S_DEV3;
            end
            // dev = (3*dev + diff) / 4
            S_DEV3:
            begin
                acc_next   = alu_res;
                state_next = S_DEV;
            end
            S_DEV:
            begin
                dev_next   = alu_res[TIME_W+1:2];
                state_next = S_RTT7;
            end
            // rtt = (7*rtt + sample) / 8
            S_RTT7:
            begin
                acc_next   = alu_res;
                state_next = S_RTT;
            end
            S_RTT:
            begin
                rtt_next   = alu_res[TIME_W+2:3];
                state_next = S_RTO;
            end
            // rto = rtt + 4*dev, saturated, then floored
            S_RTO:
            begin
                if (alu_res[ALU_W-1:TIME_W] != '0)
                    acc_next = ALU_W'(TIME_MAX);
                else
                    acc_next = ALU_W'(alu_res[TIME_W-1:0]);
                state_next = S_RTO_MIN;
            end
            S_RTO_MIN:
            begin
                rto_next   = alu_borrow ? min_rto_reg : acc_reg[TIME_W-1:0];
                state_next = S_WIN_CMP;
            end
            // slow start or avoidance
            S_WIN_CMP:
            begin
                if (alu_borrow)
                begin
                    quot_next  = ONE_SEG[QUOT_W-1:0];
                    state_next = S_WIN_ADD;
                end
                else
                begin
                    quot_next  = '0;
                    rem_next   = '0;
                    cnt_next   = DIV_TOP;
                    state_next = S_DIV;
                end
            end
            // one quotient bit of 2^16 / whole per cycle
            S_DIV:
            begin
                if (alu_borrow)
                    rem_next = op_a[THR_W-1:0];
                else
                    rem_next = alu_res[THR_W-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], !alu_borrow};
                if (cnt_reg == '0)
                    state_next = S_WIN_ADD;
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            end
            S_WIN_ADD:
            begin
                acc_next   = alu_res;
                state_next = S_WIN_SAT;
            end
            S_WIN_SAT:
            begin
                win_next   = alu_borrow ? acc_reg[WIN_W-1:0] : WIN_LIMIT;
                state_next = S_FLAG;
            end
            // timeout: borrow here means window above three segments
            S_TO_CMP:
            begin
                if (alu_borrow)
                    ssth_next = {1'b0, win_reg[WIN_W-1:FRAC_BITS+1]};
                else
                    ssth_next = floor_reg;
                win_next   = ONE_SEG;
                state_next = S_FLAG;
            end
            // slow start flag and result word
            S_FLAG:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.rto_out      = rto_reg;
                    out_data_next.window_whole = whole;
                    out_data_next.ssthresh_out = ssth_reg;
                    out_data_next.slow_start   = alu_borrow;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rtt_reg       <= RTT_RESET;
            dev_reg       <= '0;
            rto_reg       <= RTT_RESET;
            win_reg       <= ONE_SEG;
            ssth_reg      <= SSTH_RESET;
            min_rto_reg   <= MIN_RTO_RESET;
            floor_reg     <= FLOOR_RESET;
            sample_reg    <= '0;
            diff_reg      <= '0;
            acc_reg       <= '0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rtt_reg       <= rtt_next;
            dev_reg       <= dev_next;
            rto_reg       <= rto_next;
            win_reg       <= win_next;
            ssth_reg      <= ssth_next;
            min_rto_reg   <= min_rto_next;
            floor_reg     <= floor_next;
            sample_reg    <= sample_next;
            diff_reg      <= diff_next;
            acc_reg       <= acc_next;
            quot_reg      <= quot_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcprto_checker.sv @@
// Port-level checks for the TCP timeout and congestion window controller.
// Depends on tcprto_pkg; bound to tcp_rto_and_cwnd_control below.
`timescale 1ns / 1ps
`default_nettype none

module tcprto_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire tcprto_pkg::out_word_t             out_data
);
    import tcprto_pkg::*;

    // a held result word does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous word in progress");

    // window whole part stays within one to the limit
    a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.window_whole >= THR_W'(1) &&
                      out_data.window_whole <= THR_W'(1024))
        else $error("window out of range");

    // slow start flag agrees with window and threshold
    a_slow_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.slow_start |-> out_data.window_whole < out_data.ssthresh_out)
        else $error("slow start flag inconsistent");

endmodule

bind tcp_rto_and_cwnd_control tcprto_checker u_tcprto_checker (.*);

`default_nettype wire

@@ verif/tcp_rto_and_cwnd_control_chk.sv @@
// Scoreboard for the TCP timeout and congestion window controller.
// Tracks the estimator state, predicts every status word and compares it with the DUT.
// Depends on tcprto_pkg.
`timescale 1ns / 1ps

module tcp_rto_and_cwnd_control_chk
    import tcprto_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_word_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_word_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   backlog
);

    localparam logic [63:0] TIME_LIM = 64'(TIME_MAX);
    localparam logic [63:0] THR_MAX  = (64'd1 << THR_W) - 64'd1;

    // Shadow copy of the estimator and the registers
    logic [TIME_W-1:0] est_rtt;
    logic [TIME_W-1:0] est_dev;
    logic [TIME_W-1:0] est_rto;
    logic [WIN_W-1:0]  est_cwnd;
    logic [THR_W-1:0]  est_ssth;
    logic [TIME_W-1:0] reg_min_rto;
    logic [THR_W-1:0]  reg_ssth_floor;

    out_word_t status_q[$];
    out_word_t want;
    int        fail_n;

    function automatic logic [63:0] clamp(input logic [63:0] v, input logic [63:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    // Advance the estimator by one word and return the status it should report
    function automatic out_word_t step_controller(input in_word_t w);
        logic [63:0] diff;
        logic [63:0] sum;
        logic [63:0] win;
        logic [63:0] whole;
        out_word_t   res;
        if (w.mode == MODE_TIMEOUT) begin
            // halve the threshold, or fall back to the floor for tiny windows
            if (est_cwnd > THREE_SEG)
                est_ssth = THR_W'(clamp(64'(est_cwnd) >> (FRAC_BITS + 1), THR_MAX));
            else
                est_ssth = reg_ssth_floor;
            est_cwnd = ONE_SEG;
        end
        else begin
            // RTT estimate: deviation uses the old smoothed value
            if (w.sample_valid) begin
                diff = (w.rtt_meas > est_rtt) ? 64'(w.rtt_meas) - 64'(est_rtt)
                                              : 64'(est_rtt) - 64'(w.rtt_meas);
                est_dev = TIME_W'(clamp((64'(est_dev) * 3 + diff) >> 2, TIME_LIM));
                est_rtt = TIME_W'(clamp((64'(est_rtt) * 7 + 64'(w.rtt_meas)) >> 3,
                                        TIME_LIM));
                sum     = clamp(64'(est_rtt) + 64'(est_dev) * 4, TIME_LIM);
                est_rto = (sum < 64'(reg_min_rto)) ? reg_min_rto : TIME_W'(sum);
            end
            // window growth: one segment in slow start, 1/floor(window) otherwise
            win = 64'(est_cwnd);
            if (win < (64'(est_ssth) << FRAC_BITS)) begin
                win = win + 64'(ONE_SEG);
            end
            else begin
                whole = win >> FRAC_BITS;
                if (whole == 0)
                    whole = 1;
                win = win + 64'(ONE_SEG) / whole;
            end
            est_cwnd = WIN_W'(clamp(win, 64'(WIN_LIMIT)));
        end
        res.rto_out      = est_rto;
        res.window_whole = THR_W'(est_cwnd >> FRAC_BITS);
        res.ssthresh_out = est_ssth;
        res.slow_start   = (64'(est_cwnd) < (64'(est_ssth) << FRAC_BITS));
        return res;
    endfunction

    // Watch all three ports at each edge; results before new words
    always @(posedge clk) begin
        if (!rst_n) begin
            est_rtt        = RTT_RESET;
            est_dev        = '0;
            est_rto        = RTT_RESET;
            est_cwnd       = ONE_SEG;
            est_ssth       = SSTH_RESET;
            reg_min_rto    = MIN_RTO_RESET;
            reg_ssth_floor = FLOOR_RESET;
            status_q.delete();
            fail_n         = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_MIN_RTO)
                    reg_min_rto = cfg_data[TIME_W-1:0];
                else if (cfg_index == CFG_SSTH_FLOOR)
                    reg_ssth_floor = cfg_data[THR_W-1:0];
            end
            if (out_valid && out_ready) begin
                if (status_q.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("%0t: unexpected status word rto %0d win %0d ssth %0d ss %0b",
                                 $time, out_data.rto_out, out_data.window_whole,
                                 out_data.ssthresh_out, out_data.slow_start);
                end
                else begin
                    want = status_q.pop_front();
                    if (want.rto_out !== out_data.rto_out ||
                        want.window_whole !== out_data.window_whole ||
                        want.ssthresh_out !== out_data.ssthresh_out ||
                        want.slow_start !== out_data.slow_start) begin
                        fail_n++;
                        if (fail_n <= 10)
                            $display({"%0t: status word differs: expected rto %0d win %0d",
                                      " ssth %0d ss %0b, got rto %0d win %0d ssth %0d ss %0b"},
                                     $time, want.rto_out, want.window_whole,
                                     want.ssthresh_out, want.slow_start,
                                     out_data.rto_out, out_data.window_whole,
                                     out_data.ssthresh_out, out_data.slow_start);
                    end
                end
            end
            if (in_valid && in_ready)
                status_q.push_back(step_controller(in_data));
        end
        mismatches <= fail_n;
        backlog    <= status_q.size();
    end

endmodule

@@ verif/tcp_rto_and_cwnd_control_tb.sv @@
// Testbench top for the TCP timeout and congestion window controller.
// Drives directed and random words through several register settings and idling
// phases; depends on tcprto_pkg, the DUT and tcp_rto_and_cwnd_control_chk.
`timescale 1ns / 1ps

module tcp_rto_and_cwnd_control_tb;
    import tcprto_pkg::*;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_word_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int backlog;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    tcp_rto_and_cwnd_control DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tcp_rto_and_cwnd_control_chk status_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side back-pressure
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Hard stop
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic in_word_t make_word(input logic m, input logic v,
                                           input logic [TIME_W-1:0] s);
        in_word_t w;
        w.mode         = m;
        w.sample_valid = v;
        w.rtt_meas     = s;
        return w;
    endfunction

    // Random event: mostly acks, samples spread over the whole range in log steps
    function automatic in_word_t random_event(input logic [TIME_W-1:0] sample_max,
                                              input int timeout_pct);
        in_word_t w;
        w.mode         = ($urandom_range(99) < timeout_pct) ? MODE_TIMEOUT : MODE_ACK;
        w.sample_valid = ($urandom_range(3) != 0);
        case ($urandom_range(7))
            0:       w.rtt_meas = '0;
            1:       w.rtt_meas = sample_max;
            2, 3:    w.rtt_meas = TIME_W'($urandom_range(sample_max) >> $urandom_range(19));
            default: w.rtt_meas = TIME_W'($urandom_range(sample_max));
        endcase
        return w;
    endfunction

    // Offer one word; valid stays up after acceptance unless a gap follows
    task automatic send_word(input in_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop offering and wait for every outstanding status word
    task automatic drain_results();
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        do @(posedge clk); while (backlog != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] rto_floor,
                             input logic [CFG_W-1:0] thr_floor,
                             input int idle, input int stall, input int n,
                             input logic [TIME_W-1:0] sample_max, input int timeout_pct);
        drain_results();
        write_reg(CFG_MIN_RTO, rto_floor);
        write_reg(CFG_SSTH_FLOOR, thr_floor);
        cfg_we        <= 1'b0;
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n) send_word(random_event(sample_max, timeout_pct));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers, sample extremes, ignored sample fields
        send_word(make_word(MODE_ACK, 1'b0, TIME_MAX));
        send_word(make_word(MODE_ACK, 1'b1, '0));
        send_word(make_word(MODE_ACK, 1'b1, TIME_MAX));
        send_word(make_word(MODE_ACK, 1'b1, TIME_MAX));
        send_word(make_word(MODE_ACK, 1'b1, '0));
        send_word(make_word(MODE_TIMEOUT, 1'b1, TIME_MAX));
        send_word(make_word(MODE_TIMEOUT, 1'b0, '0));
        repeat (4) send_word(make_word(MODE_ACK, 1'b0, '0));
        send_word(make_word(MODE_ACK, 1'b1, RTT_RESET));
        send_word(make_word(MODE_TIMEOUT, 1'b0, TIME_MAX));
        send_word(make_word(MODE_ACK, 1'b1, 20'd1));

        // Highest timeout floor, threshold floor of one
        run_phase('1, 20'd1, 0, 0, 80, TIME_MAX, 10);
        // No floors at all, tiny samples so the timeout can decay to zero
        run_phase('0, '0, 77, 0, 130, 20'd3, 5);
        run_phase(20'd1, 20'd1024, 0, 77, 80, TIME_MAX, 15);

        // Window ramp: high bits of the floor write are dropped, two timeouts put the
        // threshold on the floor, then acks keep the window in slow start well past
        // the reset threshold
        run_phase(MIN_RTO_RESET, '1, 0, 0, 0, TIME_MAX, 0);
        send_word(make_word(MODE_TIMEOUT, 1'b0, '0));
        send_word(make_word(MODE_TIMEOUT, 1'b1, TIME_MAX));
        repeat (100) send_word(random_event(TIME_MAX, 0));

        // Writes to unused indexes must leave the registers alone
        drain_results();
        write_reg(CFG_SPARE_2, '1);
        write_reg(CFG_SPARE_3, '0);
        run_phase(20'd120, 20'd5, 23, 23, 100, TIME_MAX, 10);

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && backlog == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
